// ===== design/pbt_pkg.sv =====
// Shared constants and types for the pixel blend toward target unit.
package pbt_pkg;

  localparam int WEIGHT_FRAC_BITS = 14;

  localparam int PIX_W      = 8;
  localparam int W_W        = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_RED     = 3'd0,
    REG_TARGET_GREEN   = 3'd1,
    REG_TARGET_BLUE    = 3'd2,
    REG_TARGET_ALPHA   = 3'd3,
    REG_KEEP_WEIGHT    = 3'd4,
    REG_MAX_SATURATION = 3'd5,
    REG_ADAPTIVE_MODE  = 3'd6
  } reg_index_t;

  localparam int ONE_WEIGHT = 1 << WEIGHT_FRAC_BITS;
  localparam logic [W_W-1:0] KEEP_WEIGHT_RESET =
    (ONE_WEIGHT > 65535) ? 16'hFFFF : W_W'(ONE_WEIGHT);
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // Distance clamp and adaptive weight scaling
  localparam int DIST_LIMIT = 80;
  localparam int DIST_SCALE = DIST_LIMIT * 2;
  localparam int DIST_W     = $clog2(DIST_LIMIT + 1);
  localparam int SUM_W      = $clog2(3 * 255 + 1);
  localparam int BIAS_W     = $clog2(DIST_SCALE + 1);
  localparam int PROD_W     = W_W + BIAS_W;

  // Divide by DIST_SCALE as a shift by its power-of-two factor,
  // then a reciprocal multiply by the odd factor
  localparam int SCALE_SHIFT = 5;
  localparam int SCALE_ODD   = DIST_SCALE >> SCALE_SHIFT;
  localparam int Q_W         = PROD_W - SCALE_SHIFT;
  localparam int RECIP_SHIFT = Q_W + 3;
  localparam int RECIP_INT   = ((1 << RECIP_SHIFT) + SCALE_ODD - 1) / SCALE_ODD;
  localparam int RECIP_W     = $clog2(RECIP_INT + 1);
  localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP_INT);

  // Blend lane widths
  localparam int DIFF_W  = PIX_W + 1;
  localparam int LPROD_W = W_W + 1 + DIFF_W;
  localparam int BASE_W  = WEIGHT_FRAC_BITS + PIX_W + 1;
  localparam int ACC_W   = ((LPROD_W > BASE_W) ? LPROD_W : BASE_W) + 1;
  localparam int MAG_W   = ACC_W - 1 - WEIGHT_FRAC_BITS;

endpackage

// ===== design/pbt_lane.sv =====
// One color channel of the blend: weighted difference, then add, truncate and clamp.
module pbt_lane (
  input  logic                      clk,
  input  logic [pbt_pkg::W_W-1:0]   w,
  input  logic [pbt_pkg::PIX_W-1:0] tgt,
  input  logic [pbt_pkg::PIX_W-1:0] old,
  input  logic [pbt_pkg::PIX_W-1:0] limit,
  output logic [pbt_pkg::PIX_W-1:0] result
);
  import pbt_pkg::*;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [LPROD_W-1:0] prod;
  logic [PIX_W-1:0]          tgt_d;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   acc;
  logic [MAG_W-1:0]          mag;
  logic [PIX_W-1:0]          result_next;

  // (1 - w) * t + w * o == t * one + w * (o - t)
  assign diff = $signed({1'b0, old}) - $signed({1'b0, tgt});

  always_ff @(posedge clk) begin
    prod  <= $signed({1'b0, w}) * diff;
    tgt_d <= tgt;
  end

  assign base = $signed({{(ACC_W - PIX_W - WEIGHT_FRAC_BITS){1'b0}}, tgt_d,
                         {WEIGHT_FRAC_BITS{1'b0}}});
  assign acc  = base + ACC_W'(prod);
  assign mag  = acc[ACC_W-2:WEIGHT_FRAC_BITS];

  always_comb begin
    if (acc[ACC_W-1] || acc == '0) begin
      result_next = '0;
    end else if (mag > MAG_W'(limit)) begin
      result_next = limit;
    end else begin
      result_next = mag[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// ===== design/pixel_blend_toward_target_unit.sv =====
// Top level of the pixel blend toward target unit.
//
// Moves each RGBA pixel toward a programmed target color by a keep weight,
// optionally scaled by the pixel's L1 distance to the target.
// Input channel: drive in_red/in_green/in_blue/in_alpha with start high; the
// item is taken at that edge since busy is never raised.
// Result channel: done pulses for one cycle with out_red/out_green/out_blue/
// out_alpha valid; the receiver must take it in that cycle.
// Throughput: one item per cycle, set by a five-stage pipeline: distance,
// weight multiply, reciprocal divide by 160, per-channel multiply, then
// add and clamp.
// Configuration: wr_en writes wr_data into the register selected by
// wr_index; change registers only while no items are in flight.
// Reset clears the pipeline valid bits and loads the default registers:
// black transparent target, keep weight 1.0, saturation 255, adaptive on.
module pixel_blend_toward_target_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [pbt_pkg::PIX_W-1:0]      in_red,
  input  logic [pbt_pkg::PIX_W-1:0]      in_green,
  input  logic [pbt_pkg::PIX_W-1:0]      in_blue,
  input  logic [pbt_pkg::PIX_W-1:0]      in_alpha,
  output logic                           done,
  output logic [pbt_pkg::PIX_W-1:0]      out_red,
  output logic [pbt_pkg::PIX_W-1:0]      out_green,
  output logic [pbt_pkg::PIX_W-1:0]      out_blue,
  output logic [pbt_pkg::PIX_W-1:0]      out_alpha,
  input  logic                           wr_en,
  input  logic [pbt_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [pbt_pkg::CFG_DATA_W-1:0] wr_data
);
  import pbt_pkg::*;

  // Configuration registers
  logic [PIX_W-1:0] target_red;
  logic [PIX_W-1:0] target_green;
  logic [PIX_W-1:0] target_blue;
  logic [PIX_W-1:0] target_alpha;
  logic [W_W-1:0]   keep_weight;
  logic [PIX_W-1:0] max_saturation;
  logic             adaptive_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_red     <= '0;
      target_green   <= '0;
      target_blue    <= '0;
      target_alpha   <= '0;
      keep_weight    <= KEEP_WEIGHT_RESET;
      max_saturation <= PIX_MAX;
      adaptive_mode  <= 1'b1;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_TARGET_RED:     target_red     <= wr_data[PIX_W-1:0];
        REG_TARGET_GREEN:   target_green   <= wr_data[PIX_W-1:0];
        REG_TARGET_BLUE:    target_blue    <= wr_data[PIX_W-1:0];
        REG_TARGET_ALPHA:   target_alpha   <= wr_data[PIX_W-1:0];
        REG_KEEP_WEIGHT:    keep_weight    <= wr_data[W_W-1:0];
        REG_MAX_SATURATION: max_saturation <= wr_data[PIX_W-1:0];
        REG_ADAPTIVE_MODE:  adaptive_mode  <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Valid bits, one per stage
  logic v1, v2, v3, v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  assign done = v5;

  // Stage 1: L1 distance over RGB, limited
  logic [PIX_W-1:0]  dr, dg, db;
  logic [SUM_W-1:0]  dsum;
  logic [DIST_W-1:0] dist_next;

  assign dr   = (in_red   > target_red)   ? in_red   - target_red   : target_red   - in_red;
  assign dg   = (in_green > target_green) ? in_green - target_green : target_green - in_green;
  assign db   = (in_blue  > target_blue)  ? in_blue  - target_blue  : target_blue  - in_blue;
  assign dsum = SUM_W'(dr) + SUM_W'(dg) + SUM_W'(db);
  assign dist_next = (dsum > SUM_W'(DIST_LIMIT)) ? DIST_W'(DIST_LIMIT) : dsum[DIST_W-1:0];

  logic [DIST_W-1:0] d1;
  logic [PIX_W-1:0]  r1, g1, b1, a1;

  always_ff @(posedge clk) begin
    d1 <= dist_next;
    r1 <= in_red;
    g1 <= in_green;
    b1 <= in_blue;
    a1 <= in_alpha;
  end

  // Stage 2: keep_weight * (limit + distance)
  logic [BIAS_W-1:0] bias;
  logic [PROD_W-1:0] p2;
  logic [PIX_W-1:0]  r2, g2, b2, a2;

  assign bias = BIAS_W'(DIST_LIMIT) + BIAS_W'(d1);

  always_ff @(posedge clk) begin
    p2 <= PROD_W'(keep_weight) * PROD_W'(bias);
    r2 <= r1;
    g2 <= g1;
    b2 <= b1;
    a2 <= a1;
  end

  // Stage 3: divide by the distance scale, pick the blend weight
  logic [Q_W-1:0]         q;
  logic [Q_W+RECIP_W-1:0] qm;
  logic [W_W-1:0]         w_next;
  logic [W_W-1:0]         w3;
  logic [PIX_W-1:0]       r3, g3, b3, a3;

  assign q      = p2[PROD_W-1:SCALE_SHIFT];
  assign qm     = (Q_W+RECIP_W)'(q) * (Q_W+RECIP_W)'(RECIP_MULT);
  assign w_next = adaptive_mode ? qm[RECIP_SHIFT +: W_W] : keep_weight;

  always_ff @(posedge clk) begin
    w3 <= w_next;
    r3 <= r2;
    g3 <= g2;
    b3 <= b2;
    a3 <= a2;
  end

  // Stages 4 and 5: per-channel blend
  pbt_lane u_lane_red (
    .clk    (clk),
    .w      (w3),
    .tgt    (target_red),
    .old    (r3),
    .limit  (max_saturation),
    .result (out_red)
  );

  pbt_lane u_lane_green (
    .clk    (clk),
    .w      (w3),
    .tgt    (target_green),
    .old    (g3),
    .limit  (max_saturation),
    .result (out_green)
  );

  pbt_lane u_lane_blue (
    .clk    (clk),
    .w      (w3),
    .tgt    (target_blue),
    .old    (b3),
    .limit  (max_saturation),
    .result (out_blue)
  );

  pbt_lane u_lane_alpha (
    .clk    (clk),
    .w      (w3),
    .tgt    (target_alpha),
    .old    (a3),
    .limit  (PIX_MAX),
    .result (out_alpha)
  );

`ifndef SYNTH
  // RGB results never exceed the saturation limit used in the final stage
  assert property (@(posedge clk) disable iff (rst)
    done |-> (out_red <= $past(max_saturation)) && (out_green <= $past(max_saturation))
             && (out_blue <= $past(max_saturation)))
    else $error("blended color above saturation limit");

  // Adaptive weight lies between half the keep weight and the full keep weight
  assert property (@(posedge clk) disable iff (rst)
    (v3 && $past(adaptive_mode)) |->
      ((18'(w3) <= 18'($past(keep_weight, 2))) &&
       ((18'(w3) + 18'(w3) + 18'd1) >= 18'($past(keep_weight, 2)))))
    else $error("adaptive weight out of range");
`endif

endmodule
